// File: rtl/smm_pkg.sv
package smm_pkg;

  // Geometry and field widths
  localparam int MAX_DIM_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CMD_W           = 2;
  localparam int IDX_W           = 3;
  localparam int VAL_W           = 16;
  localparam int DIM_W           = 4;
  localparam int PROD_W          = 32;
  localparam int SUM_W           = 36;
  localparam int STAT_W          = 2;
  localparam int CFG_IDX_W       = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_code_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK  = 2'd0,
    STAT_IDX = 2'd1,
    STAT_DIM = 2'd2
  } status_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_WR_A    = 3'd0,
    OP_WR_B    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_COMPUTE = 3'd3,
    OP_IDX_ERR = 3'd4,
    OP_DIM_ERR = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [DIM_W-1:0] ar;
    logic [DIM_W-1:0] ac;
    logic [DIM_W-1:0] bc;
  } cmd_t;

endpackage

// File: rtl/smm_ram.sv
module smm_ram #(
  parameter int WIDTH = smm_pkg::VAL_W,
  parameter int DEPTH = smm_pkg::MAX_DIM_DEF * smm_pkg::MAX_DIM_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/smm_front.sv
module smm_front #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [smm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smm_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smm_pkg::CMD_W-1:0]     in_command,
  input  logic [smm_pkg::IDX_W-1:0]     in_row_index,
  input  logic [smm_pkg::IDX_W-1:0]     in_col_index,
  input  logic signed [smm_pkg::VAL_W-1:0] in_entry_value,
  input  logic                          q_full,
  output logic                          q_push,
  output smm_pkg::cmd_t                 q_wdata
);

  import smm_pkg::*;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic             a_in_range, b_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_RESET;
      a_cols_r <= DIM_RESET;
      b_rows_r <= DIM_RESET;
      b_cols_r <= DIM_RESET;
    end else if (cfg_write_en) begin
      case (reg_idx_t'(cfg_index))
        REG_A_ROWS: a_rows_r <= cfg_data;
        REG_A_COLS: a_cols_r <= cfg_data;
        REG_B_ROWS: b_rows_r <= cfg_data;
        REG_B_COLS: b_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes above the store geometry act as the geometry
  assign ar = (a_rows_r > DIM_MAX) ? DIM_MAX : a_rows_r;
  assign ac = (a_cols_r > DIM_MAX) ? DIM_MAX : a_cols_r;
  assign br = (b_rows_r > DIM_MAX) ? DIM_MAX : b_rows_r;
  assign bc = (b_cols_r > DIM_MAX) ? DIM_MAX : b_cols_r;

  assign a_in_range = ({1'b0, in_row_index} < ar) && ({1'b0, in_col_index} < ac);
  assign b_in_range = ({1'b0, in_row_index} < br) && ({1'b0, in_col_index} < bc);

  always_comb begin
    q_wdata.op    = OP_CLEAR;
    q_wdata.row   = in_row_index;
    q_wdata.col   = in_col_index;
    q_wdata.value = in_entry_value;
    q_wdata.ar    = ar;
    q_wdata.ac    = ac;
    q_wdata.bc    = bc;
    case (cmd_code_t'(in_command))
      CMD_WR_A:    q_wdata.op = a_in_range ? OP_WR_A : OP_IDX_ERR;
      CMD_WR_B:    q_wdata.op = b_in_range ? OP_WR_B : OP_IDX_ERR;
      CMD_COMPUTE: q_wdata.op = (ac != br) ? OP_DIM_ERR : OP_COMPUTE;
      CMD_CLEAR:   q_wdata.op = OP_CLEAR;
      default:     q_wdata.op = OP_CLEAR;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// File: rtl/smm_queue.sv
module smm_queue #(
  parameter int DEPTH = smm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smm_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output smm_pkg::cmd_t rdata
);

  import smm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/smm_back.sv
module smm_back #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  smm_pkg::cmd_t                   q_rdata,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [smm_pkg::STAT_W-1:0]      out_status,
  output logic [smm_pkg::IDX_W-1:0]       out_row,
  output logic [smm_pkg::IDX_W-1:0]       out_col,
  output logic signed [smm_pkg::SUM_W-1:0] out_value,
  output logic                            out_has_entry,
  output logic                            out_last
);

  import smm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AC_W  = 2 * IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_COMP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Sizes of the running product
  logic [DIM_W-1:0] ar_r, ac_r, bc_r;

  // Issue counters
  logic             issue_on_r, issue_on_nxt;
  logic [IDX_W-1:0] r_r, c_r, k_r, r_nxt, c_nxt, k_nxt;
  logic             k_first, k_last, c_last, r_last, issue_v;

  // Stores
  logic [DEPTH-1:0] a_valid_r, b_valid_r;
  logic [AW-1:0]    a_waddr, a_raddr, b_raddr;
  logic [VAL_W-1:0] a_rdata, b_rdata;
  logic             a_we, b_we;

  // Pipeline: read, multiply, accumulate
  logic                     v1_r, first1_r, last1_r, av1_r, bv1_r;
  logic [IDX_W-1:0]         r1_r, c1_r, r2_r, c2_r, r3_r, c3_r;
  logic                     v2_r, first2_r, last2_r;
  logic signed [VAL_W-1:0]  xa, xb;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  prod_ext, acc_r;
  logic                     sum_v_r;

  // Held nonzero entry, waiting to learn whether it is the last one
  logic                    pend_v_r;
  logic [IDX_W-1:0]        pend_row_r, pend_col_r;
  logic signed [SUM_W-1:0] pend_val_r;

  logic nz_sum, adv, can_emit, emit_cmd, emit_pend, emit_final, start_comp;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_value_r;
  logic                    out_has_entry_r, out_last_r;

  assign can_emit   = !out_valid_r || !out_stall;
  assign q_pop      = (state_r == ST_IDLE) && q_valid && can_emit;
  assign start_comp = q_pop && (q_rdata.op == OP_COMPUTE);
  assign emit_cmd   = q_pop && (q_rdata.op != OP_COMPUTE);

  assign nz_sum     = sum_v_r && (acc_r != '0);
  assign adv        = !(nz_sum && pend_v_r && !can_emit);
  assign emit_pend  = nz_sum && pend_v_r && can_emit;
  assign emit_final = (state_r == ST_COMP) && !issue_on_r && !v1_r && !v2_r &&
                      !sum_v_r && can_emit;

  // ---- issue counters ----
  assign issue_v = (state_r == ST_COMP) && issue_on_r;
  assign k_first = (k_r == '0);
  assign k_last  = (({1'b0, k_r} + DIM_W'(1)) == ac_r);
  assign c_last  = (({1'b0, c_r} + DIM_W'(1)) == bc_r);
  assign r_last  = (({1'b0, r_r} + DIM_W'(1)) == ar_r);

  always_comb begin
    state_nxt    = state_r;
    issue_on_nxt = issue_on_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    case (state_r)
      ST_IDLE: begin
        if (start_comp) begin
          state_nxt    = ST_COMP;
          issue_on_nxt = (q_rdata.ar != '0) && (q_rdata.ac != '0) && (q_rdata.bc != '0);
          r_nxt        = '0;
          c_nxt        = '0;
          k_nxt        = '0;
        end
      end
      ST_COMP: begin
        if (issue_v && adv) begin
          if (k_last) begin
            k_nxt = '0;
            if (c_last) begin
              c_nxt = '0;
              if (r_last) begin
                issue_on_nxt = 1'b0;
              end else begin
                r_nxt = r_r + IDX_W'(1);
              end
            end else begin
              c_nxt = c_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
        if (emit_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      issue_on_r <= 1'b0;
      r_r        <= '0;
      c_r        <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      issue_on_r <= issue_on_nxt;
      r_r        <= r_nxt;
      c_r        <= c_nxt;
      k_r        <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_comp) begin
      ar_r <= q_rdata.ar;
      ac_r <= q_rdata.ac;
      bc_r <= q_rdata.bc;
    end
  end

  // ---- stores ----
  assign a_we    = q_pop && (q_rdata.op == OP_WR_A);
  assign b_we    = q_pop && (q_rdata.op == OP_WR_B);
  assign a_waddr = AW'(({{IDX_W{1'b0}}, q_rdata.row} * AC_W'(MAX_DIM)) +
                       {{IDX_W{1'b0}}, q_rdata.col});
  assign a_raddr = AW'(({{IDX_W{1'b0}}, r_r} * AC_W'(MAX_DIM)) + {{IDX_W{1'b0}}, k_r});
  assign b_raddr = AW'(({{IDX_W{1'b0}}, k_r} * AC_W'(MAX_DIM)) + {{IDX_W{1'b0}}, c_r});

  smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH), .AW(AW)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (q_rdata.value),
    .re    (adv),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH), .AW(AW)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (a_waddr),
    .wdata (q_rdata.value),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Entry valid bits: a never-written or cleared entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= '0;
      b_valid_r <= '0;
    end else if (q_pop && (q_rdata.op == OP_CLEAR)) begin
      a_valid_r <= '0;
      b_valid_r <= '0;
    end else begin
      if (a_we) begin
        a_valid_r[a_waddr] <= 1'b1;
      end
      if (b_we) begin
        b_valid_r[a_waddr] <= 1'b1;
      end
    end
  end

  // ---- datapath pipeline, frozen while a finished sum cannot move on ----
  assign xa       = av1_r ? a_rdata : '0;
  assign xb       = bv1_r ? b_rdata : '0;
  assign prod_ext = {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      sum_v_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= issue_v;
      v2_r    <= v1_r;
      sum_v_r <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first1_r <= k_first;
      last1_r  <= k_last;
      r1_r     <= r_r;
      c1_r     <= c_r;
      av1_r    <= a_valid_r[a_raddr];
      bv1_r    <= b_valid_r[b_raddr];
      first2_r <= first1_r;
      last2_r  <= last1_r;
      r2_r     <= r1_r;
      c2_r     <= c1_r;
      prod_r   <= xa * xb;
      if (v2_r) begin
        acc_r <= first2_r ? prod_ext : acc_r + prod_ext;
        r3_r  <= r2_r;
        c3_r  <= c2_r;
      end
    end
  end

  // ---- held entry ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (start_comp || emit_final) begin
      pend_v_r <= 1'b0;
    end else if (nz_sum && adv) begin
      pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (nz_sum && adv) begin
      pend_row_r <= r3_r;
      pend_col_r <= c3_r;
      pend_val_r <= acc_r;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_cmd || emit_pend || emit_final) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend || (emit_final && pend_v_r)) begin
      out_status_r    <= STAT_OK;
      out_row_r       <= pend_row_r;
      out_col_r       <= pend_col_r;
      out_value_r     <= pend_val_r;
      out_has_entry_r <= 1'b1;
      out_last_r      <= emit_final;
    end else if (emit_cmd || emit_final) begin
      out_row_r       <= '0;
      out_col_r       <= '0;
      out_value_r     <= '0;
      out_has_entry_r <= 1'b0;
      out_last_r      <= 1'b1;
      if (emit_cmd && (q_rdata.op == OP_IDX_ERR)) begin
        out_status_r <= STAT_IDX;
      end else if (emit_cmd && (q_rdata.op == OP_DIM_ERR)) begin
        out_status_r <= STAT_DIM;
      end else begin
        out_status_r <= STAT_OK;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_has_entry = out_has_entry_r;
  assign out_last      = out_last_r;

`ifndef SYNTH
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(v1_r || v2_r || sum_v_r || pend_v_r))
    else $error("pipeline not empty while idle");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_final |=> (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("compute did not close with a last result");

  a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_entry_r) |-> (out_value_r != '0))
    else $error("product entry with zero value");

  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_entry_r) |-> out_last_r)
    else $error("result without entry not marked last");
`endif

endmodule

// File: rtl/sparse_matrix_multiply_top.sv
// A write, clear or error request passes the queue and then the output register.
// Throughput: write/clear requests sustain 1 per cycle while the result side does
//   not stall; a compute request runs one multiply-accumulate per cycle (set by the
//   single read port of each entry store) while no result-side stall holds it back.
// Reset (rst_n low, synchronous): both stores empty, all sizes 8, queue and
//   output empty. No clearing pass: per-entry valid bits clear at once.
module sparse_matrix_multiply_top #(
  parameter int MAX_DIM     = smm_pkg::MAX_DIM_DEF,
  parameter int QUEUE_DEPTH = smm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_write_en,
  input  logic [smm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smm_pkg::DIM_W-1:0]        cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [smm_pkg::CMD_W-1:0]        in_command,
  input  logic [smm_pkg::IDX_W-1:0]        in_row_index,
  input  logic [smm_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [smm_pkg::VAL_W-1:0] in_entry_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [smm_pkg::STAT_W-1:0]       out_status,
  output logic [smm_pkg::IDX_W-1:0]        out_row,
  output logic [smm_pkg::IDX_W-1:0]        out_col,
  output logic signed [smm_pkg::SUM_W-1:0] out_value,
  output logic                             out_has_entry,
  output logic                             out_last
);

  import smm_pkg::*;

  // Front -> queue: each accepted request, already classified
  // (store write, clear, compute, index error, size mismatch).
  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t q_wdata, q_rdata;

  // Front: hold the size registers, clamp them, check indexes and sizes,
  // and push one classified request per accepted input.
  smm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Short queue: lets the front keep taking requests while the back
  // is busy with a product or blocked on the result side.
  smm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // Back: own the two entry stores, run the multiply-accumulate pipeline
  // in row-major order, hold back each nonzero entry until the next one
  // (or the end) shows whether it is the last, and drive the output register.
  smm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_not_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_has_entry (out_has_entry),
    .out_last      (out_last)
  );

endmodule
